### design/otee_pkg.sv
// Package for the oblivious tree ensemble scorer: store sizes, codes,
// sequencer states and the accumulator control bundle. No dependencies.
`default_nettype none
package otee_pkg;
    localparam int MAX_TREES    = 256;
    localparam int MAX_DEPTH    = 8;
    localparam int MAX_FEATURES = 256;
    localparam int SPLIT_SLOTS  = 2048;
    localparam int LEAF_SLOTS   = 16384;
    localparam int MAX_CLASSES  = 4;

    localparam int TREE_W   = 9;   // tree counter, holds MAX_TREES itself
    localparam int DEPTH_W  = 4;
    localparam int SOFF_W   = 12;  // split offset, up to MAX_TREES * MAX_DEPTH
    localparam int LOFF_W   = 20;  // leaf offset, up to MAX_TREES * 2^8 * 4
    localparam int SLOT_W   = 21;
    localparam int CLS_W    = 3;   // class counter, holds MAX_CLASSES itself
    localparam int ACC_W    = 48;
    localparam int LEAF_W   = 32;

    localparam logic [1:0] KIND_SPLIT = 2'd0;
    localparam logic [1:0] KIND_LEAF  = 2'd1;
    localparam logic [1:0] KIND_DEPTH = 2'd2;
    localparam logic [1:0] KIND_BIN   = 2'd3;

    localparam logic [1:0] CFG_FIRST_TREE  = 2'd0;
    localparam logic [1:0] CFG_TREE_END    = 2'd1;
    localparam logic [1:0] CFG_CLASS_COUNT = 2'd2;
    localparam logic [1:0] CFG_XOR_ENABLE  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TREE_RD,
        ST_TREE_GOT,
        ST_SPLIT_RD,
        ST_SPLIT_GOT,
        ST_BIN_GOT,
        ST_LEAF_RD,
        ST_LEAF_GOT,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic       clear;
        logic       add;
        logic [1:0] idx;
    } acc_ctrl_t;
endpackage
`default_nettype wire

### design/otee_if.sv
// Valid/ready channel interfaces for load requests and class scores.
// No dependencies.
`default_nettype none
interface otee_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [13:0] address;
    logic [7:0]  split_feature;
    logic [7:0]  split_border;
    logic [7:0]  split_xor;
    logic [3:0]  depth_value;
    logic signed [31:0] leaf_value;
    logic [7:0]  bin_value;
    logic        doc_last;

    modport source (output valid, kind, address, split_feature, split_border, split_xor,
                    depth_value, leaf_value, bin_value, doc_last, input ready);
    modport sink (input valid, kind, address, split_feature, split_border, split_xor,
                  depth_value, leaf_value, bin_value, doc_last, output ready);
endinterface

interface otee_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  class_index;
    logic signed [47:0] score;
    logic        run_last;

    modport source (output valid, class_index, score, run_last, input ready);
    modport sink (input valid, class_index, score, run_last, output ready);
endinterface
`default_nettype wire

### design/otee_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module otee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

### design/otee_acc.sv
// Class accumulator bank with one shared 48-bit saturating adder.
// Depends on otee_pkg.
`default_nettype none
module otee_acc
    import otee_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire acc_ctrl_t                ctrl,
    input  wire logic signed [LEAF_W-1:0] value,
    output logic signed [ACC_W-1:0]       rd_data
);
    logic signed [ACC_W-1:0] acc_reg [MAX_CLASSES];
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] sat;

    // Shared adder, saturating when the sign of the wide sum disagrees.
    always_comb
    begin
        sum = {acc_reg[ctrl.idx][ACC_W-1], acc_reg[ctrl.idx]}
            + {{(ACC_W+1-LEAF_W){value[LEAF_W-1]}}, value};
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sat = sum[ACC_W-1:0];
        end
    end

    assign rd_data = acc_reg[ctrl.idx];

    // Accumulator registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (ctrl.add)
        begin
            acc_reg[ctrl.idx] <= sat;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_clear_and_add: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.clear && ctrl.add)) else $error("clear and add together");
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (acc_reg[0] == '0)) else $error("clear left a nonzero value");
    a_add_changes_only_target: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.add && ctrl.idx != 2'd0) |=> $stable(acc_reg[0]))
        else $error("add touched another class");
`endif
endmodule
`default_nettype wire

### design/oblivious_tree_ensemble_eval_unit.sv
// Top level of the oblivious tree ensemble scorer: configuration, stores,
// evaluation sequencer. Depends on otee_pkg, otee_if, otee_ram, otee_acc.
//
// Load requests (split, leaf, depth, bin) are taken one per cycle while idle. A bin
// request with doc_last starts an evaluation, during which no request is
// taken: each tree in 0..tree_end-1 gets a depth read, and each tree from
// first_tree on adds, per split level, a split read, a bin read and a
// compare, then per class a leaf read and an add in the shared saturating
// adder. Scores then leave one per cycle while out_item.ready is high,
// class 0 first, run_last on the final class. All stores are RAMs with one
// read port each, which sets the sequence of steps.
`default_nettype none
module oblivious_tree_ensemble_eval_unit
    import otee_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    otee_in_if.sink         in_item,
    otee_out_if.source      out_item,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data
);
    seq_state_t state_reg, state_next;

    logic [7:0]        first_reg;
    logic [8:0]        end_reg;
    logic [2:0]        cc_cfg_reg;
    logic              xor_reg;

    logic [TREE_W-1:0] t_reg, t_next;
    logic [DEPTH_W-1:0] d_reg, d_next, depth_reg, depth_next;
    logic [MAX_DEPTH-1:0] idx_reg, idx_next;
    logic [CLS_W-1:0]  c_reg, c_next, cc_reg, cc_next;
    logic [SOFF_W-1:0] soff_reg, soff_next;
    logic [LOFF_W-1:0] loff_reg, loff_next;
    logic              oob_reg, oob_next;
    logic [7:0]        border_reg, border_next, mask_reg, mask_next;

    logic              accept;
    logic [8:0]        end_eff;
    logic [2:0]        cc_eff;
    logic [DEPTH_W-1:0] depth_in;
    logic [SOFF_W-1:0] split_slot;
    logic [SLOT_W-1:0] leaf_slot;
    logic [7:0]        bin_x;
    logic [7:0]        feat;
    logic [TREE_W:0]   t_inc;
    logic [LOFF_W-1:0] loff_inc;
    logic [DEPTH_W-1:0] depth_adv;

    logic [23:0]       split_rdata;
    logic [LEAF_W-1:0] leaf_rdata;
    logic [DEPTH_W-1:0] depth_rdata;
    logic [7:0]        bin_rdata;
    logic              split_re, leaf_re, depth_re, bin_re;
    acc_ctrl_t         acc_ctrl;
    logic signed [ACC_W-1:0] acc_rd;

    assign accept  = in_item.valid && in_item.ready;
    assign end_eff = (end_reg > 9'(MAX_TREES)) ? 9'(MAX_TREES) : end_reg;
    assign cc_eff  = (cc_cfg_reg == 3'd0) ? 3'd1
                   : (cc_cfg_reg > 3'(MAX_CLASSES)) ? 3'(MAX_CLASSES) : cc_cfg_reg;
    assign depth_in = (in_item.depth_value > 4'(MAX_DEPTH)) ? 4'(MAX_DEPTH)
                    : in_item.depth_value;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            end_reg    <= '0;
            cc_cfg_reg <= 3'd1;
            xor_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_TREE:  first_reg  <= cfg_data[7:0];
                CFG_TREE_END:    end_reg    <= cfg_data;
                CFG_CLASS_COUNT: cc_cfg_reg <= cfg_data[2:0];
                CFG_XOR_ENABLE:  xor_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stores.
    otee_ram #(.WIDTH(24), .DEPTH(SPLIT_SLOTS)) u_split_ram (
        .clk(clk),
        .we(accept && in_item.kind == KIND_SPLIT && in_item.address[13:11] == 3'd0),
        .waddr(in_item.address[10:0]),
        .wdata({in_item.split_feature, in_item.split_border, in_item.split_xor}),
        .re(split_re), .raddr(split_slot[10:0]), .rdata(split_rdata));

    otee_ram #(.WIDTH(LEAF_W), .DEPTH(LEAF_SLOTS)) u_leaf_ram (
        .clk(clk),
        .we(accept && in_item.kind == KIND_LEAF),
        .waddr(in_item.address),
        .wdata(in_item.leaf_value),
        .re(leaf_re), .raddr(leaf_slot[13:0]), .rdata(leaf_rdata));

    otee_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_TREES)) u_depth_ram (
        .clk(clk),
        .we(accept && in_item.kind == KIND_DEPTH && in_item.address[13:8] == 6'd0),
        .waddr(in_item.address[7:0]),
        .wdata(depth_in),
        .re(depth_re), .raddr(t_reg[7:0]), .rdata(depth_rdata));

    otee_ram #(.WIDTH(8), .DEPTH(MAX_FEATURES)) u_bin_ram (
        .clk(clk),
        .we(accept && in_item.kind == KIND_BIN && in_item.address[13:8] == 6'd0),
        .waddr(in_item.address[7:0]),
        .wdata(in_item.bin_value),
        .re(bin_re), .raddr(feat), .rdata(bin_rdata));

    otee_acc u_acc (
        .clk(clk), .rst_n(rst_n), .ctrl(acc_ctrl),
        .value(oob_reg ? '0 : $signed(leaf_rdata)), .rd_data(acc_rd));

    // Sequencer state and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            t_reg     <= '0;
            d_reg     <= '0;
            depth_reg <= '0;
            idx_reg   <= '0;
            c_reg     <= '0;
            cc_reg    <= 3'd1;
            soff_reg  <= '0;
            loff_reg  <= '0;
            oob_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            d_reg     <= d_next;
            depth_reg <= depth_next;
            idx_reg   <= idx_next;
            c_reg     <= c_next;
            cc_reg    <= cc_next;
            soff_reg  <= soff_next;
            loff_reg  <= loff_next;
            oob_reg   <= oob_next;
        end
    end

    always_ff @(posedge clk)
    begin
        border_reg <= border_next;
        mask_reg   <= mask_next;
    end

    // Next state, addresses and outputs.
    always_comb
    begin
        state_next  = state_reg;
        t_next      = t_reg;
        d_next      = d_reg;
        depth_next  = depth_reg;
        idx_next    = idx_reg;
        c_next      = c_reg;
        cc_next     = cc_reg;
        soff_next   = soff_reg;
        loff_next   = loff_reg;
        oob_next    = oob_reg;
        border_next = border_reg;
        mask_next   = mask_reg;
        split_re    = 1'b0;
        leaf_re     = 1'b0;
        depth_re    = 1'b0;
        bin_re      = 1'b0;
        acc_ctrl    = '{clear: 1'b0, add: 1'b0, idx: c_reg[1:0]};
        in_item.ready  = 1'b0;
        out_item.valid = 1'b0;

        split_slot = soff_reg + SOFF_W'(d_reg);
        leaf_slot  = SLOT_W'(loff_reg) + SLOT_W'(idx_reg) * SLOT_W'(cc_reg)
                   + SLOT_W'(c_reg);
        feat       = oob_reg ? 8'd0 : split_rdata[23:16];
        bin_x      = xor_reg ? (bin_rdata ^ mask_reg) : bin_rdata;
        t_inc      = {1'b0, t_reg} + 1'b1;
        depth_adv  = (state_reg == ST_TREE_GOT) ? depth_rdata : depth_reg;
        loff_inc   = LOFF_W'((LOFF_W'(1) << depth_adv) * cc_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                in_item.ready = 1'b1;
                if (accept && in_item.kind == KIND_BIN && in_item.doc_last)
                begin
                    acc_ctrl.clear = 1'b1;
                    cc_next   = cc_eff;
                    t_next    = '0;
                    soff_next = '0;
                    loff_next = '0;
                    c_next    = '0;
                    state_next = (end_eff == 9'd0) ? ST_EMIT : ST_TREE_RD;
                end
            end
            ST_TREE_RD:
            begin
                depth_re   = 1'b1;
                state_next = ST_TREE_GOT;
            end
            ST_TREE_GOT:
            begin
                depth_next = depth_rdata;
                d_next     = '0;
                idx_next   = '0;
                c_next     = '0;
                if (t_reg < TREE_W'(first_reg))
                begin
                    // Tree outside the range: only advance the offsets and the tree counter.
                    soff_next  = soff_reg + SOFF_W'(depth_rdata);
                    loff_next  = loff_reg + loff_inc;
                    t_next     = t_inc[TREE_W-1:0];
                    state_next = (t_inc == {1'b0, end_eff}) ? ST_EMIT : ST_TREE_RD;
                end
                else
                begin
                    state_next = ST_SPLIT_RD;
                end
            end
            ST_SPLIT_RD:
            begin
                if (d_reg == depth_reg)
                begin
                    state_next = ST_LEAF_RD;
                end
                else
                begin
                    split_re   = 1'b1;
                    oob_next   = (split_slot >= SOFF_W'(SPLIT_SLOTS));
                    state_next = ST_SPLIT_GOT;
                end
            end
            ST_SPLIT_GOT:
            begin
                // Feature numbers are 8 bits wide, so every bin read is in range.
                bin_re      = 1'b1;
                border_next = oob_reg ? 8'd0 : split_rdata[15:8];
                mask_next   = oob_reg ? 8'd0 : split_rdata[7:0];
                state_next  = ST_BIN_GOT;
            end
            ST_BIN_GOT:
            begin
                if (bin_x >= border_reg)
                begin
                    idx_next[d_reg[2:0]] = 1'b1;
                end
                d_next     = d_reg + 1'b1;
                state_next = ST_SPLIT_RD;
            end
            ST_LEAF_RD:
            begin
                leaf_re    = 1'b1;
                oob_next   = (leaf_slot >= SLOT_W'(LEAF_SLOTS));
                state_next = ST_LEAF_GOT;
            end
            ST_LEAF_GOT:
            begin
                acc_ctrl.add = 1'b1;
                if (c_reg + 1'b1 == cc_reg)
                begin
                    c_next     = '0;
                    soff_next  = soff_reg + SOFF_W'(depth_reg);
                    loff_next  = loff_reg + loff_inc;
                    t_next     = t_inc[TREE_W-1:0];
                    state_next = (t_inc == {1'b0, end_eff}) ? ST_EMIT : ST_TREE_RD;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_LEAF_RD;
                end
            end
            ST_EMIT:
            begin
                out_item.valid = 1'b1;
                if (out_item.ready)
                begin
                    if (c_reg + 1'b1 == cc_reg)
                    begin
                        c_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_item.class_index = c_reg[1:0];
    assign out_item.score       = acc_rd;
    assign out_item.run_last    = (c_reg + 1'b1 == cc_reg);

`ifndef NO_ASSERTIONS
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid |-> !in_item.ready) else $error("request taken while scoring");
    a_tree_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (t_reg <= end_eff)) else $error("tree counter overran");
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && out_item.ready && out_item.run_last) |=> !out_item.valid)
        else $error("score after run_last");
    a_class_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEAF_GOT || state_reg == ST_EMIT) |-> (c_reg < cc_reg))
        else $error("class counter overran");
`endif
endmodule
`default_nettype wire
